/* rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU page replacement package
// Shared widths, defaults and the control structs that travel between cells.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int FRAMES_DEF     = 4;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   localparam int PAGE_NUMBER_W  = 16;
   localparam int FRAME_INDEX_W  = 2;
   localparam int FAULT_W        = 16;

   // control part of the search token
   typedef struct packed {
      logic valid;
      logic found;
      logic have_best;
   } lfu_tok_ctl_type;

   // control part of the update broadcast
   typedef struct packed {
      logic en;
      logic miss;
   } lfu_upd_ctl_type;

endpackage

/* rtl/lfu_if.sv */
// ----------------------------------------------------------------------------
// LFU channel interfaces
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface lfu_req_if;
   import lfu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [PAGE_NUMBER_W-1:0] page_number;
   logic                     last_reference;

   modport source (output valid, output page_number, output last_reference, input ready);
   modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface

interface lfu_rsp_if;
   import lfu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [FRAME_INDEX_W-1:0] frame_index;
   logic [FAULT_W-1:0]       fault_total;
   logic                     sequence_end;

   modport source (output valid, output hit, output frame_index, output fault_total,
                   output sequence_end, input ready);
   modport sink   (input valid, input hit, input frame_index, input fault_total,
                   input sequence_end, output ready);
endinterface

/* rtl/lfu_cell.sv */
// ----------------------------------------------------------------------------
// LFU frame cell
// Holds one frame (valid, page, use count). Checks the passing search token
// for a hit and for a lower count, then hands it on from a register in the next cycle.
// ----------------------------------------------------------------------------
module lfu_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 2,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lfu_pkg::lfu_tok_ctl_type tok_ctl_in,
   input  logic [PAGE_BITS-1:0]    tok_page_in,
   input  logic [IDX_W-1:0]        tok_hit_idx_in,
   input  logic [IDX_W-1:0]        tok_best_idx_in,
   input  logic [COUNT_BITS-1:0]   tok_best_cnt_in,
   output lfu_pkg::lfu_tok_ctl_type tok_ctl_out,
   output logic [PAGE_BITS-1:0]    tok_page_out,
   output logic [IDX_W-1:0]        tok_hit_idx_out,
   output logic [IDX_W-1:0]        tok_best_idx_out,
   output logic [COUNT_BITS-1:0]   tok_best_cnt_out,
   input  lfu_pkg::lfu_upd_ctl_type upd_ctl,
   input  logic [IDX_W-1:0]        upd_idx,
   input  logic [PAGE_BITS-1:0]    upd_page
);
   import lfu_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic                  valid_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [COUNT_BITS-1:0] count_ff;

   lfu_tok_ctl_type       ctl_ff, ctl_in;
   logic [PAGE_BITS-1:0]  tpage_ff;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic                  match;
   logic                  sel;

   assign match = valid_ff && (page_ff == tok_page_in);
   assign sel   = upd_ctl.en && (upd_idx == MY_IDX);

   always_comb begin
      ctl_in      = tok_ctl_in;
      hit_idx_in  = tok_hit_idx_in;
      best_idx_in = tok_best_idx_in;
      best_cnt_in = tok_best_cnt_in;
      if (!tok_ctl_in.found && match) begin
         ctl_in.found = 1'b1;
         hit_idx_in   = MY_IDX;
      end
      if (!tok_ctl_in.have_best || (count_ff < tok_best_cnt_in)) begin
         ctl_in.have_best = 1'b1;
         best_idx_in      = MY_IDX;
         best_cnt_in      = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      tpage_ff    <= tok_page_in;
      hit_idx_ff  <= hit_idx_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else if (sel) begin
         if (upd_ctl.miss) begin
            valid_ff <= 1'b1;
            count_ff <= COUNT_BITS'(1);
         end else if (count_ff != '1) begin
            count_ff <= count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sel && upd_ctl.miss) begin
         page_ff <= upd_page;
      end
   end

   assign tok_ctl_out      = ctl_ff;
   assign tok_page_out     = tpage_ff;
   assign tok_hit_idx_out  = hit_idx_ff;
   assign tok_best_idx_out = best_idx_ff;
   assign tok_best_cnt_out = best_cnt_ff;

endmodule

/* rtl/lfu_page_replacement.sv */
// ----------------------------------------------------------------------------
// LFU page replacement
// Least-frequently-used replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one page reference per beat (page_number, last_reference).
//   rsp_chan returns one beat per reference: hit, frame_index, fault_total and
//   sequence_end (the echo of last_reference).
//   A search token walks the frame cells, one cell per cycle, picking up the
//   lowest matching valid frame and the lowest-count frame (lowest index on
//   ties). After the last cell it is held in a done stage; the frame update and the
//   fault counter step happen when the result moves into the output register.
//   The result passes the entry stage, the cell row, the done stage and the output register.
//   A new reference is taken only after the previous one has moved into the output
//   register; one reference is in flight at a time.
//   Reset (synchronous): all frames empty, use counts and fault total zero.
//   When the receiver stalls, the finished reference waits in the done stage;
//   frame state is not touched and no new request is taken until it moves out.
// ----------------------------------------------------------------------------
module lfu_page_replacement #(
   parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
   parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   lfu_req_if.sink  req_chan,
   lfu_rsp_if.source rsp_chan
);
   import lfu_pkg::*;

   localparam int IDX_W = $clog2(FRAMES);

   // token chain, entry at 0, last cell output at FRAMES
   lfu_tok_ctl_type       ch_ctl      [FRAMES+1];
   logic [PAGE_BITS-1:0]  ch_page     [FRAMES+1];
   logic [IDX_W-1:0]      ch_hit_idx  [FRAMES+1];
   logic [IDX_W-1:0]      ch_best_idx [FRAMES+1];
   logic [COUNT_BITS-1:0] ch_best_cnt [FRAMES+1];

   lfu_tok_ctl_type       entry_ctl_ff;
   logic [PAGE_BITS-1:0]  entry_page_ff;
   logic                  last_ff;
   logic                  busy_ff, busy_in;

   logic                  done_ff, done_in;
   logic                  done_found_ff;
   logic [IDX_W-1:0]      done_idx_ff;
   logic [PAGE_BITS-1:0]  done_page_ff;

   logic [FAULT_W-1:0]    fault_ff, fault_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff;
   logic [FRAME_INDEX_W-1:0] rsp_idx_ff;
   logic [FAULT_W-1:0]       rsp_fault_ff;
   logic                     rsp_end_ff;

   logic            accept;
   logic            commit;
   lfu_upd_ctl_type upd_ctl;
   logic [FRAMES:0] in_flight;

   assign accept = req_chan.valid && req_chan.ready;
   assign commit = done_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = !busy_ff;

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctl_ff <= '0;
      end else begin
         entry_ctl_ff.valid     <= accept;
         entry_ctl_ff.found     <= 1'b0;
         entry_ctl_ff.have_best <= 1'b0;
      end
      if (accept) begin
         entry_page_ff <= PAGE_BITS'(req_chan.page_number);
         last_ff       <= req_chan.last_reference;
      end
   end

   assign ch_ctl[0]      = entry_ctl_ff;
   assign ch_page[0]     = entry_page_ff;
   assign ch_hit_idx[0]  = '0;
   assign ch_best_idx[0] = '0;
   assign ch_best_cnt[0] = '0;

   assign upd_ctl.en   = commit;
   assign upd_ctl.miss = !done_found_ff;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      lfu_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IDX_W),
         .PAGE_BITS  (PAGE_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .tok_ctl_in       (ch_ctl[i]),
         .tok_page_in      (ch_page[i]),
         .tok_hit_idx_in   (ch_hit_idx[i]),
         .tok_best_idx_in  (ch_best_idx[i]),
         .tok_best_cnt_in  (ch_best_cnt[i]),
         .tok_ctl_out      (ch_ctl[i+1]),
         .tok_page_out     (ch_page[i+1]),
         .tok_hit_idx_out  (ch_hit_idx[i+1]),
         .tok_best_idx_out (ch_best_idx[i+1]),
         .tok_best_cnt_out (ch_best_cnt[i+1]),
         .upd_ctl          (upd_ctl),
         .upd_idx          (done_idx_ff),
         .upd_page         (done_page_ff)
      );
      assign in_flight[i] = ch_ctl[i+1].valid;
   end
   assign in_flight[FRAMES] = done_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (commit) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      done_in = done_ff;
      if (ch_ctl[FRAMES].valid) begin
         done_in = 1'b1;
      end else if (commit) begin
         done_in = 1'b0;
      end
   end

   always_comb begin
      fault_in = fault_ff;
      if (commit && !done_found_ff && (fault_ff != '1)) begin
         fault_in = fault_ff + FAULT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ch_ctl[FRAMES].valid) begin
         done_found_ff <= ch_ctl[FRAMES].found;
         done_idx_ff   <= ch_ctl[FRAMES].found ? ch_hit_idx[FRAMES] : ch_best_idx[FRAMES];
         done_page_ff  <= ch_page[FRAMES];
      end
      if (commit) begin
         rsp_hit_ff   <= done_found_ff;
         rsp_idx_ff   <= FRAME_INDEX_W'(done_idx_ff);
         rsp_fault_ff <= fault_in;
         rsp_end_ff   <= last_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_hit_ff;
   assign rsp_chan.frame_index  = rsp_idx_ff;
   assign rsp_chan.fault_total  = rsp_fault_ff;
   assign rsp_chan.sequence_end = rsp_end_ff;

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0(in_flight))
      else $error("more than one reference in flight");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (in_flight == '0))
      else $error("token present while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !req_chan.ready)
      else $error("request taken without going busy");

   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && !busy_ff && !done_ff)
      else $error("commit did not load output register");
`endif

endmodule

/* tb/lfu_page_replacement_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFU page replacement testbench
// Streams page references through the request channel and checks every result
// beat against a shadow of the frame table: hit/miss, frame picked, fault total
// and the end-of-sequence echo. A directed warm-up walks the empty-frame fill,
// hits, lowest-count and tie eviction. Random sequences over a small working
// set follow. A run with no idle gaps then lets one hot page climb well
// above every other count while fresh misses keep evicting the rest.
// ----------------------------------------------------------------------------
module lfu_page_replacement_tb;
   import lfu_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 7;
   localparam int FRAMES       = FRAMES_DEF;
   localparam int PAGE_BITS    = PAGE_BITS_DEF;
   localparam int COUNT_BITS   = COUNT_BITS_DEF;
   localparam int IDLE_PCT     = 36;
   localparam int RANDOM_REFS  = 1200;
   localparam int WORKING_SET  = 6;
   localparam int WARM_HITS    = 100;
   localparam int SAT_PAIRS    = 100;
   localparam int DRAIN_CYCLES = 2 * (FRAMES + 3);
   localparam int STALL_LIMIT  = 1000;

   localparam logic [FAULT_W-1:0]    FAULT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [PAGE_NUMBER_W-1:0] page_number;
      logic                     last_reference;
      logic                     steady;
   } page_ref_type;

   typedef struct packed {
      logic                     hit;
      logic [FRAME_INDEX_W-1:0] frame_index;
      logic [FAULT_W-1:0]       fault_total;
      logic                     sequence_end;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset;

   lfu_req_if req_chan ();
   lfu_rsp_if rsp_chan ();

   lfu_page_replacement u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   page_ref_type      ref_backlog [$];
   lookup_result_type due_results [$];
   page_ref_type      next_ref;
   page_ref_type      taken_ref;
   lookup_result_type due;
   logic              calm;
   int                mismatches = 0;
   int                quiet_cycles;

   // shadow frame table
   logic                  frame_valid [FRAMES];
   logic [PAGE_BITS-1:0]  frame_page  [FRAMES];
   logic [COUNT_BITS-1:0] use_count   [FRAMES];
   logic [FAULT_W-1:0]    fault_count;

   function automatic lookup_result_type resolve_reference(input page_ref_type r);
      lookup_result_type    res;
      logic [PAGE_BITS-1:0] page;
      int                   slot;
      logic                 found;
      page  = r.page_number[PAGE_BITS-1:0];
      slot  = 0;
      found = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
         if (!found && frame_valid[i] && frame_page[i] == page) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         if (use_count[slot] != COUNT_MAX)
            use_count[slot] = use_count[slot] + 1'b1;
      end else begin
         // lowest count wins, lowest index on ties
         for (int i = 1; i < FRAMES; i++)
            if (use_count[i] < use_count[slot])
               slot = i;
         frame_valid[slot] = 1'b1;
         frame_page[slot]  = page;
         use_count[slot]   = COUNT_BITS'(1);
         if (fault_count != FAULT_MAX)
            fault_count = fault_count + 1'b1;
      end
      res.hit          = found;
      res.frame_index  = slot[FRAME_INDEX_W-1:0];
      res.fault_total  = fault_count;
      res.sequence_end = r.last_reference;
      return res;
   endfunction

   task automatic queue_ref(input logic [PAGE_NUMBER_W-1:0] page, input logic last,
                            input logic steady);
      page_ref_type r;
      r.page_number    = page;
      r.last_reference = last;
      r.steady         = steady;
      ref_backlog.push_back(r);
   endtask

   task automatic check_field(input string field, input logic [FAULT_W-1:0] want,
                              input logic [FAULT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (ref_backlog.size() > 0 &&
             (ref_backlog[0].steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_ref = ref_backlog.pop_front();
            req_chan.valid          <= 1'b1;
            req_chan.page_number    <= next_ref.page_number;
            req_chan.last_reference <= next_ref.last_reference;
            calm                    <= next_ref.steady;
         end else begin
            req_chan.valid          <= 1'b0;
            req_chan.page_number    <= $urandom;
            req_chan.last_reference <= $urandom;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // predictor and result checker
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            frame_valid[i] = 1'b0;
            use_count[i]   = '0;
         end
         fault_count = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result beat: hit=%0b frame=%0d fault_total=%0d end=%0b",
                        $time, rsp_chan.hit, rsp_chan.frame_index, rsp_chan.fault_total,
                        rsp_chan.sequence_end);
               mismatches++;
            end else begin
               due = due_results.pop_front();
               check_field("hit", due.hit, rsp_chan.hit);
               check_field("frame_index", due.frame_index, rsp_chan.frame_index);
               check_field("fault_total", due.fault_total, rsp_chan.fault_total);
               check_field("sequence_end", due.sequence_end, rsp_chan.sequence_end);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            taken_ref.page_number    = req_chan.page_number;
            taken_ref.last_reference = req_chan.last_reference;
            taken_ref.steady         = 1'b0;
            due_results.push_back(resolve_reference(taken_ref));
         end
      end
   end

   // watchdog: cycles without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     due_results.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [PAGE_NUMBER_W:0]   directed [] = '{
         {16'h0000, 1'b0}, {16'hFFFF, 1'b0}, {16'h0000, 1'b0}, {16'h5555, 1'b0},
         {16'hAAAA, 1'b1}, {16'hFFFF, 1'b0}, {16'hFFFF, 1'b0}, {16'h5555, 1'b0},
         {16'h1234, 1'b0}, {16'h8000, 1'b0}, {16'h8000, 1'b0}, {16'h4321, 1'b0},
         {16'h0000, 1'b0}, {16'hFFFF, 1'b1}, {16'h7FFF, 1'b0}, {16'h0001, 1'b0},
         {16'hFFFE, 1'b0}, {16'h8000, 1'b1}, {16'hAAAA, 1'b1}
      };
      logic [PAGE_NUMBER_W-1:0] working_set [WORKING_SET];
      logic [PAGE_NUMBER_W-1:0] hot_page;
      logic [PAGE_NUMBER_W-1:0] page;
      logic                     last;
      logic                     broken;
      int                       seq_len;
      int                       produced;

      reset                   = 1'b1;
      calm                    = 1'b0;
      quiet_cycles            = 0;
      req_chan.valid          = 1'b0;
      req_chan.page_number    = '0;
      req_chan.last_reference = 1'b0;
      rsp_chan.ready          = 1'b0;

      // fill in index order, hits, lowest-count eviction, tie on lowest index
      foreach (directed[i])
         queue_ref(directed[i][PAGE_NUMBER_W:1], directed[i][0], 1'b0);

      // sequences over a drifting working set, some with stray end marks
      foreach (working_set[i])
         working_set[i] = $urandom;
      produced = 0;
      while (produced < RANDOM_REFS) begin
         seq_len = $urandom_range(1, 40);
         broken  = ($urandom_range(99) < 10);
         working_set[$urandom_range(WORKING_SET - 1)] = $urandom;
         for (int k = 0; k < seq_len; k++) begin
            if ($urandom_range(99) < 70)
               page = working_set[$urandom_range($urandom_range(WORKING_SET - 1))];
            else
               page = $urandom;
            last = broken ? 1'($urandom_range(1)) : (k == seq_len - 1);
            queue_ref(page, last, produced >= 600 && produced < 800);
            produced++;
         end
      end

      // hot page climbs past every other count, then hits interleave with
      // fresh misses that keep evicting the low-count frames
      hot_page = $urandom;
      for (int k = 0; k < WARM_HITS; k++)
         queue_ref(hot_page, 1'b0, 1'b1);
      for (int k = 0; k < SAT_PAIRS; k++) begin
         queue_ref(hot_page, 1'b0, 1'b1);
         queue_ref(hot_page + 16'(1 + k % 65535), k == SAT_PAIRS - 1, 1'b1);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (ref_backlog.size() != 0 || req_chan.valid)
         @(posedge clock);
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && due_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
